// ===== design/bsws_pkg.sv =====
// ----------------------------------------------------------------------------
// bsws_pkg: shared types and constants for the bounded stack with search
// operation codes, field widths and the controller/datapath link structs
// ----------------------------------------------------------------------------
package bsws_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int MODE_W        = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // reported top word when the stack is empty, and found index for no match
    localparam logic signed [DATA_W-1:0]  TOP_NONE   = '1;
    localparam logic signed [COUNT_W-1:0] FOUND_NONE = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;          // latch a new item, clear flags
        logic push_wr;       // write entry, bump fill level
        logic push_ovf;      // flag dropped push
        logic pop;           // drop top entry, fetch the one below
        logic top_load;      // take fetched word as new top
        logic search_start;  // fetch top entry, distance zero
        logic search_step;   // fetch next entry down, distance up
        logic found_set;     // record current distance as the match
        logic emit;          // load the result register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              single;       // exactly one entry held
        logic              search_hit;   // fetched entry equals target
        logic              search_last;  // fetched entry is the bottom one
        logic              out_busy;     // result register cannot take a beat
    } status_t;

endpackage

// ===== design/bsws_in_if.sv =====
// ----------------------------------------------------------------------------
// bsws_in_if: request channel of the stack
// valid/ready handshake carrying one operation per beat
// ----------------------------------------------------------------------------
interface bsws_in_if;

    logic                                 valid;
    logic                                 ready;
    logic [bsws_pkg::MODE_W-1:0]          mode;
    logic signed [bsws_pkg::DATA_W-1:0]   push_value;
    logic signed [bsws_pkg::DATA_W-1:0]   search_target;

    modport source (
        output valid,
        output mode,
        output push_value,
        output search_target,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  push_value,
        input  search_target,
        output ready
    );

endinterface

// ===== design/bsws_out_if.sv =====
// ----------------------------------------------------------------------------
// bsws_out_if: result channel of the stack
// valid/ready handshake carrying one status report per beat
// ----------------------------------------------------------------------------
interface bsws_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [bsws_pkg::DATA_W-1:0]   top_value;
    logic                                 is_empty;
    logic [bsws_pkg::COUNT_W-1:0]         entry_count;
    logic signed [bsws_pkg::COUNT_W-1:0]  found_index;
    logic                                 overflow;

    modport source (
        output valid,
        output top_value,
        output is_empty,
        output entry_count,
        output found_index,
        output overflow,
        input  ready
    );

    modport sink (
        input  valid,
        input  top_value,
        input  is_empty,
        input  entry_count,
        input  found_index,
        input  overflow,
        output ready
    );

endinterface

// ===== design/bsws_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsws_ctrl: operation sequencer
// walks each beat through decode, memory fetch or search scan, and result
// ----------------------------------------------------------------------------
module bsws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsws_pkg::status_t  status,
    output bsws_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DECODE   = 5'b00010,
        S_POP_WAIT = 5'b00100,
        S_SEARCH   = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (status.mode)
                    bsws_pkg::MODE_PUSH:
                    begin
                        if (status.full)
                            cmd.push_ovf = 1'b1;
                        else
                            cmd.push_wr = 1'b1;
                    end
                    bsws_pkg::MODE_POP:
                    begin
                        if (!status.empty)
                        begin
                            cmd.pop = 1'b1;
                            // with one entry left the stack goes empty, no fetch
                            if (!status.single)
                                state_next = S_POP_WAIT;
                        end
                    end
                    bsws_pkg::MODE_SEARCH:
                    begin
                        if (!status.empty)
                        begin
                            cmd.search_start = 1'b1;
                            state_next       = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        // unused code: report state unchanged
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.top_load = 1'b1;
                state_next   = S_DONE;
            end
            S_SEARCH:
            begin
                if (status.search_hit)
                begin
                    cmd.found_set = 1'b1;
                    state_next    = S_DONE;
                end
                else if (status.search_last)
                    state_next = S_DONE;
                else
                    cmd.search_step = 1'b1;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/bsws_dp.sv =====
// ----------------------------------------------------------------------------
// bsws_dp: stack datapath
// entry memory, fill level, top word, search scan and result register
// ----------------------------------------------------------------------------
module bsws_dp #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bsws_pkg::cmd_t                        cmd,
    output bsws_pkg::status_t                     status,
    input  logic [bsws_pkg::MODE_W-1:0]           mode,
    input  logic signed [bsws_pkg::DATA_W-1:0]    push_value,
    input  logic signed [bsws_pkg::DATA_W-1:0]    search_target,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bsws_pkg::DATA_W-1:0]    top_value,
    output logic                                  is_empty,
    output logic [bsws_pkg::COUNT_W-1:0]          entry_count,
    output logic signed [bsws_pkg::COUNT_W-1:0]   found_index,
    output logic                                  overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [bsws_pkg::DATA_W-1:0] mem [DEPTH];

    logic [bsws_pkg::MODE_W-1:0]          mode_reg;
    logic [bsws_pkg::DATA_W-1:0]          value_reg;
    logic [bsws_pkg::DATA_W-1:0]          target_reg;
    logic [bsws_pkg::DATA_W-1:0]          top_reg;
    logic [bsws_pkg::DATA_W-1:0]          rd_data_reg;
    logic [CW-1:0]                        fill_reg;
    logic [AW-1:0]                        dist_reg;
    logic                                 ovf_reg;
    logic [bsws_pkg::COUNT_W-1:0]         found_reg;
    logic                                 out_valid_reg;

    logic signed [bsws_pkg::DATA_W-1:0]   top_value_reg;
    logic                                 is_empty_reg;
    logic [bsws_pkg::COUNT_W-1:0]         entry_count_reg;
    logic signed [bsws_pkg::COUNT_W-1:0]  found_index_reg;
    logic                                 overflow_reg;

    logic [CW-1:0] fill_m1;
    logic [CW-1:0] fill_m2;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign fill_m1 = fill_reg - CW'(1);
    assign fill_m2 = fill_reg - CW'(2);
    assign wr_addr = AW'(fill_reg);

    // fetch address: the new top on pop, top on search start,
    // otherwise the entry under the one just compared
    always_comb
    begin
        if (cmd.pop)
            rd_addr = AW'(fill_m2);
        else if (cmd.search_start)
            rd_addr = AW'(fill_m1);
        else
            rd_addr = AW'(fill_m2) - dist_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
            mem[wr_addr] <= value_reg;
        rd_data_reg <= mem[rd_addr];
    end

    assign status.mode        = mode_reg;
    assign status.full        = (fill_reg == CW'(DEPTH));
    assign status.empty       = (fill_reg == '0);
    assign status.single      = (fill_reg == CW'(1));
    assign status.search_hit  = (rd_data_reg == target_reg);
    assign status.search_last = (CW'(dist_reg) == fill_m1);
    assign status.out_busy    = out_valid_reg & ~out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push_wr)
                fill_reg <= fill_reg + CW'(1);
            else if (cmd.pop)
                fill_reg <= fill_m1;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            value_reg  <= push_value;
            target_reg <= search_target;
            ovf_reg    <= 1'b0;
            found_reg  <= bsws_pkg::FOUND_NONE;
        end
        if (cmd.push_ovf)
            ovf_reg <= 1'b1;
        if (cmd.push_wr)
            top_reg <= value_reg;
        else if (cmd.top_load)
            top_reg <= rd_data_reg;
        if (cmd.search_start)
            dist_reg <= '0;
        else if (cmd.search_step)
            dist_reg <= dist_reg + AW'(1);
        if (cmd.found_set)
            found_reg <= bsws_pkg::COUNT_W'(dist_reg);

        if (cmd.emit)
        begin
            top_value_reg   <= status.empty ? bsws_pkg::TOP_NONE : top_reg;
            is_empty_reg    <= status.empty;
            entry_count_reg <= bsws_pkg::COUNT_W'(fill_reg);
            found_index_reg <= found_reg;
            overflow_reg    <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign is_empty    = is_empty_reg;
    assign entry_count = entry_count_reg;
    assign found_index = found_index_reg;
    assign overflow    = overflow_reg;

endmodule

// ===== design/bounded_stack_with_search.sv =====
// request beat to result beat: push, the unused code, pop on an empty stack, pop of the
//   last entry and search on an empty stack go through decode and result; a pop leaving
//   entries adds a fetch; search: decode, then a scan from the top until a match or the
//   bottom entry, one entry read per cycle through the single read port, then result
// one request in flight, next beat taken once the result is registered
// reset clears fill level, sequencer and result valid; entry memory is not cleared
// ----------------------------------------------------------------------------
// bounded_stack_with_search: lifo stack of 32-bit words with top-down search
// controller sequences each request, datapath holds the entries and counters
// ----------------------------------------------------------------------------
module bounded_stack_with_search #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    bsws_in_if.sink     item,
    bsws_out_if.source  result
);

    bsws_pkg::cmd_t    cmd;
    bsws_pkg::status_t status;

    // sequencer: request beat taken only in idle, one operation at a time
    bsws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: entry memory with registered read, fill level, top word,
    // search distance counter and the result register that feeds the port
    bsws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (item.mode),
        .push_value    (item.push_value),
        .search_target (item.search_target),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .top_value     (result.top_value),
        .is_empty      (result.is_empty),
        .entry_count   (result.entry_count),
        .found_index   (result.found_index),
        .overflow      (result.overflow)
    );

endmodule

// ===== dv/tb_bounded_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_search: self-checking bench for the bounded stack
// drives push, pop, search and the unused code through the request channel,
// predicts every status report and compares it field by field on the result
// channel, under random sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_search;

    import bsws_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int STACK_DEPTH  = DEPTH_DEFAULT;
    localparam int RANDOM_OPS   = 2000;
    localparam int IDLE_LIMIT   = 2000;                // cycles with no beat on either side
    localparam int SETTLE_WAIT  = 2 * (STACK_DEPTH + 4); // comfortably above the longest search

    // the one code the block has no operation for
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    // one request waiting to be driven; hold_for_drain makes the sender
    // wait until every report owed so far has come back
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] push_value;
        logic [DATA_W-1:0] search_target;
        logic              hold_for_drain;
    } stack_req_t;

    // one status report as seen on the result channel
    typedef struct packed {
        logic signed [DATA_W-1:0]  top_value;
        logic                      is_empty;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [COUNT_W-1:0] found_index;
        logic                      overflow;
    } stack_report_t;

    logic clk = 1'b0;
    logic rst_n;

    bsws_in_if  item_if ();
    bsws_out_if result_if ();

    bounded_stack_with_search #(
        .DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    stack_req_t    pending_reqs[$];     // filled up front, drained by the sender
    stack_report_t owed_reports[$];     // predicted reports not yet seen
    logic          req_beat_seen;       // request beat at the last rising edge
    int            mismatch_count = 0;
    int            idle_cycles = 0;

    // shadow of the stack contents for prediction
    logic [DATA_W-1:0] shadow_words [STACK_DEPTH];
    int                shadow_fill = 0;

    // value pool so that searches hit, and duplicates exercise first-match
    logic [DATA_W-1:0] value_pool [16];

    // sender burst shaping
    int burst_left = 1;
    int gap_left = 0;

    // receiver stall pattern
    int       rx_phase = 0;
    int       rx_style = 0;
    logic [7:0] rx_mask = 8'hFF;
    int       rx_long_stall = 0;

    // ------------------------------------------------------------------
    // prediction: apply one operation to the shadow stack, return the report
    // ------------------------------------------------------------------
    function automatic stack_report_t apply_stack_op(
        input logic [MODE_W-1:0] op,
        input logic [DATA_W-1:0] value,
        input logic [DATA_W-1:0] target
    );
        stack_report_t r;
        int            hop;
        r.found_index = FOUND_NONE;
        r.overflow    = 1'b0;
        case (op)
            MODE_PUSH:
            begin
                if (shadow_fill < STACK_DEPTH)
                begin
                    shadow_words[shadow_fill] = value;
                    shadow_fill++;
                end
                else
                begin
                    r.overflow = 1'b1;
                end
            end
            MODE_POP:
            begin
                // pop on empty leaves everything as it is
                if (shadow_fill > 0)
                    shadow_fill--;
            end
            MODE_SEARCH:
            begin
                // walk down from the top, first hit wins
                for (hop = 0; hop < shadow_fill; hop++)
                begin
                    if (shadow_words[shadow_fill - 1 - hop] == target)
                    begin
                        r.found_index = COUNT_W'(hop);
                        break;
                    end
                end
            end
            default: ;  // unused code: state reported unchanged
        endcase
        r.top_value   = (shadow_fill > 0) ? shadow_words[shadow_fill - 1] : TOP_NONE;
        r.is_empty    = (shadow_fill == 0);
        r.entry_count = COUNT_W'(shadow_fill);
        return r;
    endfunction

    task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    endtask

    task automatic queue_req(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                             input logic [DATA_W-1:0] target, input logic drain);
        stack_req_t r;
        r.mode           = mode;
        r.push_value     = value;
        r.search_target  = target;
        r.hold_for_drain = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return value_pool[$urandom_range(0, 15)];
        else if (roll < 85)
            return $urandom;
        else
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return WORD_ZERO;
                default: return WORD_ONES;
            endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus build, reset, and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int epoch_left;
        int epoch_kind;
        int push_pct;
        int pop_pct;
        int roll;
        int n;

        rst_n = 1'b0;

        value_pool[0] = WORD_MAX;
        value_pool[1] = WORD_MIN;
        value_pool[2] = WORD_ZERO;
        value_pool[3] = WORD_ONES;
        for (n = 4; n < 16; n++)
            value_pool[n] = $urandom;

        // directed: empty-stack corners first
        queue_req(MODE_POP,    WORD_ONES, WORD_ONES, 1'b0);   // pop when empty
        queue_req(MODE_SEARCH, WORD_ZERO, WORD_ZERO, 1'b0);   // search on empty
        queue_req(MODE_NOP,    WORD_ONES, WORD_ONES, 1'b0);   // unused code, empty
        // field extremes, with a duplicate to check first-match from the top
        queue_req(MODE_PUSH,   WORD_MIN,  WORD_ZERO, 1'b0);
        queue_req(MODE_PUSH,   WORD_MAX,  WORD_ONES, 1'b0);
        queue_req(MODE_PUSH,   WORD_ZERO, WORD_MAX,  1'b0);
        queue_req(MODE_PUSH,   WORD_ONES, WORD_MIN,  1'b0);   // top of all ones while not empty
        queue_req(MODE_PUSH,   WORD_MAX,  WORD_ZERO, 1'b0);
        queue_req(MODE_SEARCH, WORD_ZERO, WORD_MIN,  1'b0);   // bottom entry
        queue_req(MODE_SEARCH, WORD_MIN,  WORD_MAX,  1'b0);   // duplicate, nearest wins
        queue_req(MODE_SEARCH, WORD_ZERO, WORD_ONES, 1'b0);
        queue_req(MODE_SEARCH, WORD_ONES, 32'h0000_3039, 1'b0); // miss
        queue_req(MODE_NOP,    WORD_ZERO, WORD_ZERO, 1'b0);   // unused code, with entries
        queue_req(MODE_POP,    WORD_ZERO, WORD_ZERO, 1'b0);
        queue_req(MODE_POP,    WORD_MAX,  WORD_MIN,  1'b0);
        queue_req(MODE_SEARCH, WORD_ZERO, WORD_MAX,  1'b0);   // only the deeper copy left
        queue_req(MODE_POP,    WORD_MIN,  WORD_MAX,  1'b0);
        queue_req(MODE_POP,    WORD_ONES, WORD_ZERO, 1'b0);
        queue_req(MODE_POP,    WORD_ZERO, WORD_ONES, 1'b0);   // back to empty
        queue_req(MODE_POP,    WORD_ZERO, WORD_ZERO, 1'b0);   // pop when empty again
        queue_req(MODE_SEARCH, WORD_ZERO, WORD_MIN,  1'b0);

        // fill to the brim and past it: overflow, deepest search, then drain
        queue_req(MODE_PUSH, 32'h5A5A_0001, $urandom, 1'b1);
        for (n = 1; n < STACK_DEPTH + 2; n++)
            queue_req(MODE_PUSH, $urandom, $urandom, 1'b0);
        queue_req(MODE_SEARCH, $urandom, 32'h5A5A_0001, 1'b0);
        queue_req(MODE_NOP,    $urandom, $urandom, 1'b0);
        queue_req(MODE_SEARCH, $urandom, $urandom, 1'b0);     // full-depth miss
        for (n = 0; n < STACK_DEPTH + 3; n++)
            queue_req(MODE_POP, $urandom, $urandom, 1'b0);

        // random part: epochs that grow, shrink or hover, so the fill level
        // sweeps the whole range and hits both ends
        epoch_left = 0;
        push_pct   = 35;
        pop_pct    = 30;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (epoch_left == 0)
            begin
                epoch_left = $urandom_range(20, 150);
                epoch_kind = $urandom_range(0, 2);
                push_pct   = (epoch_kind == 0) ? 60 : (epoch_kind == 1) ? 10 : 35;
                pop_pct    = (epoch_kind == 0) ? 10 : (epoch_kind == 1) ? 55 : 30;
                if ($urandom_range(0, 4) == 0)
                    value_pool[$urandom_range(4, 15)] = $urandom;
            end
            epoch_left--;
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                queue_req(MODE_PUSH, pick_word(), $urandom, ($urandom_range(0, 99) == 0));
            else if (roll < push_pct + pop_pct)
                queue_req(MODE_POP, $urandom, $urandom, ($urandom_range(0, 99) == 0));
            else if (roll < 95)
                queue_req(MODE_SEARCH, $urandom, pick_word(), ($urandom_range(0, 99) == 0));
            else
                queue_req(MODE_NOP, $urandom, $urandom, 1'b0);
        end

        // reset once, released away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every request to go out and every report to come back
        while (pending_reqs.size() != 0 || item_if.valid || owed_reports.size() != 0)
            @(posedge clk);
        // then give a stray late report time to show up
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("bounded_stack_with_search: match");
        else
            $display("bounded_stack_with_search: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender: one request per beat, bursts with random gaps, falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : req_driver
        stack_req_t r;
        logic       slot_free;
        if (!rst_n)
        begin
            item_if.valid         <= 1'b0;
            item_if.mode          <= MODE_PUSH;
            item_if.push_value    <= '0;
            item_if.search_target <= '0;
        end
        else
        begin
            slot_free = !item_if.valid || req_beat_seen;
            if (slot_free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_if.valid         <= 1'b0;
                    item_if.mode          <= 2'($urandom);
                    item_if.push_value    <= $urandom;
                    item_if.search_target <= $urandom;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].hold_for_drain && owed_reports.size() != 0))
                begin
                    r = pending_reqs.pop_front();
                    item_if.valid         <= 1'b1;
                    item_if.mode          <= r.mode;
                    item_if.push_value    <= r.push_value;
                    item_if.search_target <= r.search_target;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    // nothing to send, or holding until all reports are back
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready always high, from a mask or at random, the style redrawn at each phase wrap,
    // with the odd long stall so results back up behind a busy output
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : rsp_stall
        logic nxt_ready;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (rx_long_stall > 0)
            begin
                rx_long_stall--;
                nxt_ready = 1'b0;
            end
            else
            begin
                if (rx_phase == 0)
                begin
                    rx_style = $urandom_range(0, 2);
                    rx_mask  = 8'($urandom_range(1, 255));
                end
                case (rx_style)
                    0:       nxt_ready = 1'b1;
                    1:       nxt_ready = rx_mask[rx_phase % 8];
                    default: nxt_ready = $urandom_range(0, 1);
                endcase
                rx_phase = (rx_phase + 1) % 32;
                if ($urandom_range(0, 299) == 0)
                    rx_long_stall = $urandom_range(10, 40);
            end
            result_if.ready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // checker: compare each report beat with the oldest prediction, then
    // predict for a request beat at the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : report_check
        stack_report_t got;
        stack_report_t want;
        if (!rst_n)
        begin
            req_beat_seen <= 1'b0;
        end
        else
        begin
            req_beat_seen <= item_if.valid && item_if.ready;
            if (result_if.valid && result_if.ready)
            begin
                got.top_value   = result_if.top_value;
                got.is_empty    = result_if.is_empty;
                got.entry_count = result_if.entry_count;
                got.found_index = result_if.found_index;
                got.overflow    = result_if.overflow;
                if (owed_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: report beat expected none, actual %h", $time, got);
                end
                else
                begin
                    want = owed_reports.pop_front();
                    if (got.top_value !== want.top_value)
                        flag_field("top_value", want.top_value, got.top_value);
                    if (got.is_empty !== want.is_empty)
                        flag_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
                    if (got.entry_count !== want.entry_count)
                        flag_field("entry_count", DATA_W'(want.entry_count),
                                   DATA_W'(got.entry_count));
                    if (got.found_index !== want.found_index)
                        flag_field("found_index", DATA_W'(want.found_index),
                                   DATA_W'(got.found_index));
                    if (got.overflow !== want.overflow)
                        flag_field("overflow", DATA_W'(want.overflow), DATA_W'(got.overflow));
                end
            end
            if (item_if.valid && item_if.ready)
                owed_reports.push_back(apply_stack_op(item_if.mode, item_if.push_value,
                                                      item_if.search_target));
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no beat on either channel for too long ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : hang_watch
        if (rst_n)
        begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("bounded_stack_with_search: mismatch");
                $finish;
            end
        end
    end

endmodule

// ===== bounded_stack_with_search.f =====
design/bsws_pkg.sv
design/bsws_in_if.sv
design/bsws_out_if.sv
design/bsws_ctrl.sv
design/bsws_dp.sv
design/bounded_stack_with_search.sv
dv/tb_bounded_stack_with_search.sv
